// ===== rtl/ecal_pkg.sv =====
// Shared types, constants and helpers for the epoch-seconds to calendar converter.
package ecal_pkg;

  // Serial divider widths
  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 11;
  localparam int unsigned CountW    = 6;

  // Divisors used by the conversion steps
  localparam logic [DivisorW-1:0] DivSixty = 11'd60;
  localparam logic [DivisorW-1:0] DivDay   = 11'd24;
  localparam logic [DivisorW-1:0] DivQuad  = 11'd1461;

  // Quotient bit counts for each division step
  localparam logic [CountW-1:0] BitsSec  = 6'd32;
  localparam logic [CountW-1:0] BitsMin  = 6'd27;
  localparam logic [CountW-1:0] BitsHour = 6'd21;
  localparam logic [CountW-1:0] BitsQuad = 6'd16;

  localparam logic [11:0] EpochYear   = 12'd1970;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [1:0]  LeapSlot    = 2'd2;   // third year of a four-year group
  localparam logic [1:0]  LastSlot    = 2'd3;
  localparam logic [3:0]  MonthFeb    = 4'd1;
  localparam logic [3:0]  MonthDec    = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_DIV_HOUR,
    ST_DIV_QUAD,
    ST_YEAR,
    ST_MONTH,
    ST_SPARE
  } state_e;

  // Request from the sequencer to the serial divider
  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;  // left-aligned: top nbits are significant
    logic [DivisorW-1:0]  divisor;
    logic [CountW-1:0]    nbits;
  } div_req_t;

  // Divider status and results
  typedef struct packed {
    logic                 busy;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

  // Month length, zero-based month index, February stretched in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
    logic [4:0] len;
    case (mi)
      MonthFeb:                  len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/ecal_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ecal_div
  import ecal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvsr_q, dvsr_d;
  logic [DivisorW:0]    trial;
  logic                 ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DividendW-1]};
  assign ge    = trial >= {1'b0, dvsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (req_i.start) begin
      cnt_d  = req_i.nbits;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvsr_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DividendW-2:0], ge};
      rem_d = ge ? DivisorW'(trial - {1'b0, dvsr_q}) : DivisorW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign rsp_o.busy      = cnt_q != '0;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// From accepted word to result: serial divides of 32, 27, 21 and 16 quotient bits,
// then 1 to 4 year steps and 1 to 12 month steps; a stalled output holds the last
// month step. Throughput: one word at a time; the input stalls until the sequencer idles.
// A finished result sits in the output register while the next word is converted.
// Reset (async, active low) idles the sequencer, empties the output and sets zone to 8.
// Top level: converts seconds since 1970 into second, minute, hour, day, month and year.
module epoch_seconds_to_calendar
  import ecal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // zone register
  input  logic        zone_hours_we_i,
  input  logic [4:0]  zone_hours_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [11:0] year_o
);

  state_e      state_q, state_d;
  logic [4:0]  zone_q;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // working registers
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  quads_q, quads_d;
  logic [1:0]  yi_q, yi_d;
  logic [3:0]  mi_q, mi_d;
  logic [10:0] rem_q, rem_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [5:0]  osec_q, osec_d;
  logic [5:0]  omin_q, omin_d;
  logic [4:0]  ohr_q, ohr_d;
  logic [4:0]  oday_q, oday_d;
  logic [3:0]  omon_q, omon_d;
  logic [11:0] oyear_q, oyear_d;

  logic [16:0] offset;
  logic [31:0] t_adj;
  logic [20:0] hours;
  logic [10:0] ylen;
  logic [4:0]  mlen;
  logic        leap;
  logic        month_fin;

  // zone offset removal on the incoming word
  assign offset = 17'(zone_q) * SecsPerHour;
  assign t_adj  = (epoch_seconds_i >= {15'b0, offset})
                ? epoch_seconds_i - {15'b0, offset} : epoch_seconds_i;

  // whole hours plus zone
  assign hours = div_rsp.quotient[20:0] + 21'(zone_q);

  // year and month walk terms
  assign leap      = yi_q == LeapSlot;
  assign ylen      = leap ? 11'd366 : 11'd365;
  assign mlen      = month_len(mi_q, leap);
  assign month_fin = (mi_q == MonthDec) || (rem_q < {6'b0, mlen});

  ecal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // zone register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= 5'd8;
    end else if (zone_hours_we_i) begin
      zone_q <= zone_hours_i;
    end
  end

  // sequencer: next state, divider requests, working and output registers
  always_comb begin
    state_d  = state_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hr_d     = hr_q;
    quads_d  = quads_q;
    yi_d     = yi_q;
    mi_d     = mi_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q && out_stall_i;
    osec_d   = osec_q;
    omin_d   = omin_q;
    ohr_d    = ohr_q;
    oday_d   = oday_q;
    omon_d   = omon_q;
    oyear_d  = oyear_q;
    div_req  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          div_req.start    = 1'b1;
          div_req.dividend = t_adj;
          div_req.divisor  = DivSixty;
          div_req.nbits    = BitsSec;
          state_d          = ST_DIV_SEC;
        end
      end
      ST_DIV_SEC: begin
        if (!div_rsp.busy) begin
          sec_d            = div_rsp.remainder[5:0];
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.quotient[26:0], 5'b0};
          div_req.divisor  = DivSixty;
          div_req.nbits    = BitsMin;
          state_d          = ST_DIV_MIN;
        end
      end
      ST_DIV_MIN: begin
        if (!div_rsp.busy) begin
          min_d            = div_rsp.remainder[5:0];
          div_req.start    = 1'b1;
          div_req.dividend = {hours, 11'b0};
          div_req.divisor  = DivDay;
          div_req.nbits    = BitsHour;
          state_d          = ST_DIV_HOUR;
        end
      end
      ST_DIV_HOUR: begin
        if (!div_rsp.busy) begin
          hr_d             = div_rsp.remainder[4:0];
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.quotient[15:0], 16'b0};
          div_req.divisor  = DivQuad;
          div_req.nbits    = BitsQuad;
          state_d          = ST_DIV_QUAD;
        end
      end
      ST_DIV_QUAD: begin
        if (!div_rsp.busy) begin
          quads_d = div_rsp.quotient[5:0];
          rem_d   = div_rsp.remainder;
          yi_d    = '0;
          state_d = ST_YEAR;
        end
      end
      ST_YEAR: begin
        // a remainder equal to the year length rolls into the next year
        if (yi_q == LastSlot || rem_q < ylen) begin
          mi_d    = '0;
          state_d = ST_MONTH;
        end else begin
          rem_d = rem_q - ylen;
          yi_d  = yi_q + 1'b1;
        end
      end
      ST_MONTH: begin
        if (!month_fin) begin
          rem_d = rem_q - {6'b0, mlen};
          mi_d  = mi_q + 1'b1;
        end else if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          osec_d   = sec_q;
          omin_d   = min_q;
          ohr_d    = hr_q;
          oday_d   = 5'(rem_q + 11'd1);
          omon_d   = mi_q + 4'd1;
          oyear_d  = EpochYear + {4'b0, quads_q, 2'b00} + {10'b0, yi_q};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q   <= sec_d;
    min_q   <= min_d;
    hr_q    <= hr_d;
    quads_q <= quads_d;
    yi_q    <= yi_d;
    mi_q    <= mi_d;
    rem_q   <= rem_d;
    osec_q  <= osec_d;
    omin_q  <= omin_d;
    ohr_q   <= ohr_d;
    oday_q  <= oday_d;
    omon_q  <= omon_d;
    oyear_q <= oyear_d;
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = ovalid_q;
  assign second_o       = osec_q;
  assign minute_o       = omin_q;
  assign hour_o         = ohr_q;
  assign day_of_month_o = oday_q;
  assign month_o        = omon_q;
  assign year_o         = oyear_q;

`ifndef NO_ASSERTIONS
  // divider only runs while a division step is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_DIV_SEC || state_q == ST_DIV_MIN ||
                      state_q == ST_DIV_HOUR || state_q == ST_DIV_QUAD))
    else $error("divider busy outside a division step");

  // a new result is only loaded at the end of the month walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_MONTH)
    else $error("result loaded outside month walk");

  // results hold a real month and day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o != 5'd0))
    else $error("month or day out of range");

  // the year walk never leaves a remainder past a full year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MONTH |-> rem_q < 11'd366)
    else $error("day remainder beyond one year");
`endif

endmodule
